[sv/mhpq_pkg.sv]
// Shared types, constants and helpers for the max-heap priority queue.
// No dependencies; imported by mhpq_cell and max_heap_priority_queue_core.
package mhpq_pkg;

    localparam int DATA_W       = 32;
    localparam int CNT_W        = 11;   // width of the reported count field
    localparam int IDX_W        = 17;   // node index, wide enough for the largest capacity
    localparam int SH_W         = 5;    // level number / shift amount
    localparam int CAPACITY_DEF = 1024;

    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_TUSER_W  = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // token kinds walking down the cell chain
    localparam logic OP_INS = 1'b0;   // top-down insert along the path to the new slot
    localparam logic OP_DN  = 1'b1;   // sift-down after an extract

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    // request handed from one level to the next
    typedef struct packed {
        logic                      vld;
        logic                      op;
        logic signed [DATA_W-1:0]  val;   // value being carried
        logic [IDX_W-1:0]          node;  // insert: target slot; sift-down: parent node
        logic [IDX_W-1:0]          cnt;   // sift-down: element count
        logic [SH_W-1:0]           sh;    // insert: levels left to the target slot
    } t_tok;

    // write from a level into the level above it
    typedef struct packed {
        logic                      en;
        logic [IDX_W-1:0]          node;
        logic signed [DATA_W-1:0]  data;
    } t_upwr;

    // broadcast read used by extract to fetch root and last element
    typedef struct packed {
        logic                      en;
        logic [IDX_W-1:0]          node;
        logic [SH_W-1:0]           lvl;
    } t_fetch;

    // per-level status back to the controller
    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0]  fdata;
    } t_csts;

    // position of the highest set bit (level of a 1-based node index)
    function automatic logic [SH_W-1:0] msb_pos(input logic [IDX_W-1:0] x);
        logic [SH_W-1:0] r;
        r = '0;
        for (int i = 0; i < IDX_W; i++) begin
            if (x[i]) r = SH_W'(i);
        end
        return r;
    endfunction

endpackage

[sv/mhpq_cell.sv]
// One heap level: the level's node storage plus its read/compare/write step.
// Depends on mhpq_pkg; instantiated once per level by the top level.
module mhpq_cell
    import mhpq_pkg::*;
#(
    parameter int LEVEL    = 0,
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_tok   i_tok,
    output t_tok   o_tok,
    input  t_upwr  i_upwr,
    output t_upwr  o_upwr,
    input  t_fetch i_fetch,
    output t_csts  o_sts
);

    // nodes of this level are 2^LEVEL .. min(2^(LEVEL+1)-1, CAPACITY), stored as sibling pairs
    localparam int TOP_IDX  = (1 << (LEVEL + 1)) - 1;
    localparam int LAST_IDX = (TOP_IDX < CAPACITY) ? TOP_IDX : CAPACITY;
    localparam int HALF     = 1 << ((LEVEL > 0) ? LEVEL - 1 : 0);
    localparam int ROWS     = (LEVEL == 0) ? 1 : (LAST_IDX >> 1) - HALF + 1;
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [IDX_W-1:0] ROW_MASK = (LEVEL <= 1) ? '0 : IDX_W'(HALF - 1);

    function automatic logic [RW-1:0] row_of(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i >> 1) & ROW_MASK;
        return r[RW-1:0];
    endfunction

    function automatic logic side_of(input logic [IDX_W-1:0] i);
        return (LEVEL == 0) ? 1'b0 : i[0];
    endfunction

    logic signed [DATA_W-1:0] r_mem_lo [ROWS];
    logic signed [DATA_W-1:0] r_mem_hi [ROWS];
    logic signed [DATA_W-1:0] r_rd_lo, r_rd_hi;

    logic   r_vld, r_ph, r_fside;
    t_tok   r_tok;

    logic                     w_act, w_fhit;
    logic [IDX_W-1:0]         w_ins_node, w_c0, w_c1, w_big_node, w_rd_node;
    logic signed [DATA_W-1:0] w_ins_old, w_big_val;
    logic                     w_ok0, w_ok1, w_pick1, w_grand;
    logic                     w_own_wr, w_pass;
    logic [IDX_W-1:0]         w_own_node;
    t_tok                     w_nxt;
    t_upwr                    w_up;
    logic                     w_wr_en;
    logic [IDX_W-1:0]         w_wr_node;
    logic signed [DATA_W-1:0] w_wr_data;

    // phase 0: row read issued; phase 1: decide and write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ph  <= 1'b0;
        end else if (i_tok.vld) begin
            r_vld <= 1'b1;
            r_ph  <= 1'b0;
        end else if (r_vld && r_ph) begin
            r_vld <= 1'b0;
        end else if (r_vld) begin
            r_ph  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) r_tok <= i_tok;
        if (w_fhit)    r_fside <= side_of(i_fetch.node);
    end

    assign w_act      = r_vld && r_ph;
    assign w_fhit     = i_fetch.en && ((LEVEL == 0) || (i_fetch.lvl == SH_W'(LEVEL)));
    assign w_ins_node = r_tok.node >> r_tok.sh;
    assign w_c0       = {r_tok.node[IDX_W-2:0], 1'b0};
    assign w_c1       = {r_tok.node[IDX_W-2:0], 1'b1};
    assign w_rd_node  = w_fhit ? i_fetch.node : ((r_tok.op == OP_INS) ? w_ins_node : w_c0);

    // node storage: one write port, one registered read per half
    always_ff @(posedge i_clk) begin
        if (w_wr_en && !side_of(w_wr_node)) r_mem_lo[row_of(w_wr_node)] <= w_wr_data;
        if (w_wr_en &&  side_of(w_wr_node)) r_mem_hi[row_of(w_wr_node)] <= w_wr_data;
        r_rd_lo <= r_mem_lo[row_of(w_rd_node)];
        r_rd_hi <= r_mem_hi[row_of(w_rd_node)];
    end

    assign w_ins_old  = side_of(w_ins_node) ? r_rd_hi : r_rd_lo;
    assign w_ok0      = w_c0 <= r_tok.cnt;
    assign w_ok1      = w_c1 <= r_tok.cnt;
    assign w_pick1    = w_ok1 && ($signed(r_rd_hi) > $signed(r_rd_lo));
    assign w_big_node = w_pick1 ? w_c1 : w_c0;
    assign w_big_val  = w_pick1 ? r_rd_hi : r_rd_lo;
    assign w_grand    = ({w_big_node, 1'b0}) <= {1'b0, r_tok.cnt};

    always_comb begin
        w_own_wr   = 1'b0;
        w_own_node = w_ins_node;
        w_pass     = 1'b0;
        w_nxt      = r_tok;
        w_up       = '0;
        if (w_act) begin
            if (r_tok.op == OP_INS) begin
                if (r_tok.sh == '0) begin
                    w_own_wr = 1'b1;          // reached the new slot
                end else begin
                    w_pass   = 1'b1;
                    w_nxt.sh = r_tok.sh - 1'b1;
                    if ($signed(w_ins_old) < $signed(r_tok.val)) begin
                        w_own_wr  = 1'b1;     // keep the larger, carry the smaller on
                        w_nxt.val = w_ins_old;
                    end
                end
            end else begin
                w_up.en   = 1'b1;
                w_up.node = r_tok.node;
                w_up.data = r_tok.val;
                if (w_ok0 && ($signed(w_big_val) > $signed(r_tok.val))) begin
                    w_up.data = w_big_val;    // promote the larger child
                    if (w_grand) begin
                        w_pass     = 1'b1;
                        w_nxt.node = w_big_node;
                    end else begin
                        w_own_wr   = 1'b1;    // child is a leaf: value settles here
                        w_own_node = w_big_node;
                    end
                end
            end
        end
        w_nxt.vld = w_pass;
    end

    assign w_wr_en   = w_own_wr || i_upwr.en;
    assign w_wr_node = w_own_wr ? w_own_node : i_upwr.node;
    assign w_wr_data = w_own_wr ? r_tok.val  : i_upwr.data;

    assign o_tok       = w_nxt;
    assign o_upwr      = w_up;
    assign o_sts.done  = w_act && !w_pass;
    assign o_sts.fdata = r_fside ? r_rd_hi : r_rd_lo;

endmodule

[sv/max_heap_priority_queue_core.sv]
// Max-heap priority queue: one request at a time; the depth of the path that a request walks
// is at most floor(log2 CAPACITY). Each heap level is a cell with its own storage; at each
// level a request does a registered row read, then a compare and write. Results sit in an
// output register, so the next request is taken while a result waits. Synchronous active-low
// reset clears the count and control; node storage is not cleared and holds nothing
// meaningful until written.
module max_heap_priority_queue_core
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  logic                   i_s_axis_tuser,   // [0] cmd
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] result_value, [42:32] count
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser    // [1:0] status
);

    // node indices 1..CAPACITY span NL levels; the count needs the same width
    localparam int NL = $clog2(CAPACITY + 1);
    localparam int CW = NL;
    localparam int LW = $clog2(NL);

    // controller states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;  // insert token walking down
    localparam logic [2:0] S_FREQ  = 3'd2;  // fetch of root and last element issued
    localparam logic [2:0] S_FETCH = 3'd3;  // fetched data available
    localparam logic [2:0] S_DN    = 3'd4;  // sift-down token walking down
    localparam logic [2:0] S_OUT   = 3'd5;  // hand result to the output register

    logic [2:0]               r_state;
    logic [CW-1:0]            r_cnt;
    logic [IDX_W-1:0]         r_node;
    logic [SH_W-1:0]          r_lvl;
    logic signed [DATA_W-1:0] r_res;
    logic [1:0]               r_status;
    logic                     r_lvld;
    t_tok                     r_ltok;
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_res;
    logic [1:0]               r_out_st;
    logic [CNT_W-1:0]         r_out_cnt;

    logic                     w_acc, w_full, w_empty, w_out_load;
    logic [IDX_W-1:0]         w_cnt_x, w_ins_n;
    logic [NL-1:0]            w_done;
    logic signed [DATA_W-1:0] w_fdata [NL];
    t_tok                     w_tok_out [NL];
    t_upwr                    w_up [NL+1];
    t_csts                    w_sts [NL];
    t_fetch                   w_fetch;

    assign w_acc      = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_cnt_x    = IDX_W'(r_cnt);
    assign w_ins_n    = w_cnt_x + 1'b1;          // slot of a new element (1-based)
    assign w_full     = r_cnt >= CW'(CAPACITY);
    assign w_empty    = r_cnt == '0;
    assign w_out_load = (r_state == S_OUT) && (!r_out_vld || i_m_axis_tready);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_s_axis_tuser)
                            CMD_INSERT: begin
                                if (w_full) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_cnt   <= r_cnt + 1'b1;
                                    r_state <= S_INS;
                                end
                            end
                            CMD_EXTRACT: begin
                                if (w_empty) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_cnt   <= r_cnt - 1'b1;
                                    r_state <= S_FREQ;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FREQ:  r_state <= S_FETCH;
                S_FETCH: begin
                    if (w_empty) begin
                        r_state <= S_OUT;        // removed the only element
                    end else begin
                        r_state <= S_DN;
                    end
                end
                S_INS, S_DN: begin
                    if (|w_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // one-cycle launch pulse for the token held in r_ltok
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= 1'b0;
        end else begin
            r_lvld <= (w_acc && (i_s_axis_tuser == CMD_INSERT) && !w_full) ||
                      ((r_state == S_FETCH) && !w_empty);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res    <= (i_s_axis_tuser == CMD_EXTRACT && w_empty) ? EMPTY_VALUE : '0;
            if (i_s_axis_tuser == CMD_INSERT && w_full) begin
                r_status <= ST_FULL;
            end else if (i_s_axis_tuser == CMD_EXTRACT && w_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
            r_node   <= w_cnt_x;
            r_lvl    <= msb_pos(w_cnt_x);
            r_ltok.op   <= OP_INS;
            r_ltok.val  <= $signed(i_s_axis_tdata[DATA_W-1:0]);
            r_ltok.node <= w_ins_n;
            r_ltok.cnt  <= '0;
            r_ltok.sh   <= msb_pos(w_ins_n);
            r_ltok.vld  <= 1'b0;
        end
        if (r_state == S_FETCH) begin
            r_res       <= w_fdata[0];           // old root is the maximum
            r_ltok.op   <= OP_DN;
            r_ltok.val  <= w_fdata[r_lvl[LW-1:0]]; // last element restarts at the root
            r_ltok.node <= IDX_W'(1);
            r_ltok.cnt  <= w_cnt_x;
            r_ltok.sh   <= '0;
        end
        if (w_out_load) begin
            r_out_res <= r_res;
            r_out_st  <= r_status;
            r_out_cnt <= w_cnt_x[CNT_W-1:0];
        end
    end

    // broadcast read: root from level 0, last element from its own level
    assign w_fetch.en   = r_state == S_FREQ;
    assign w_fetch.node = r_node;
    assign w_fetch.lvl  = r_lvl;

    // nothing writes up into the last level
    assign w_up[NL] = '0;

    for (genvar k = 0; k < NL; k++) begin : g_cell
        t_tok w_in;
        if (k == 0) begin : g_root
            always_comb begin
                w_in     = r_ltok;
                w_in.vld = r_lvld && (r_ltok.op == OP_INS);
            end
        end else if (k == 1) begin : g_first
            // sift-down starts here: its first step compares the root's children
            always_comb begin
                if (w_tok_out[0].vld) begin
                    w_in = w_tok_out[0];
                end else begin
                    w_in     = r_ltok;
                    w_in.vld = r_lvld && (r_ltok.op == OP_DN);
                end
            end
        end else begin : g_rest
            assign w_in = w_tok_out[k-1];
        end

        mhpq_cell #(
            .LEVEL    (k),
            .CAPACITY (CAPACITY)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_in),
            .o_tok   (w_tok_out[k]),
            .i_upwr  (w_up[k+1]),
            .o_upwr  (w_up[k]),
            .i_fetch (w_fetch),
            .o_sts   (w_sts[k])
        );

        assign w_done[k]  = w_sts[k].done;
        assign w_fdata[k] = w_sts[k].fdata;
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - DATA_W - CNT_W)'(0), r_out_cnt, r_out_res};
    assign o_m_axis_tuser  = r_out_st;

    // the deepest level never forwards a request
    a_last_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tok_out[NL-1].vld)
        else $error("request forwarded past the deepest level");

    // the root level has nothing above it to write into
    a_root_no_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_up[0].en)
        else $error("write issued above the root");

    // one request in flight: at most one level finishes per cycle
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done))
        else $error("several levels finished at once");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS || r_state == S_DN) && (|w_done)) |=> (r_state == S_OUT))
        else $error("finished request not passed to the output");

endmodule
